// File: hw/rtl/lcdns_pkg.sv
// shared types, codes and constants of the character lcd nibble sequencer
package lcdns_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;
    localparam int unsigned INIT_LEN       = 6;
    localparam int unsigned HOLD_W         = 17;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned CFG_IDX_W      = 2;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_HOME   = 3'd2,
        ACT_CURSOR = 3'd3,
        ACT_CHAR   = 3'd4
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_STROBE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME   = 2'd3;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] NIBBLE_HI    = 8'hF0;
    localparam logic [7:0] NIBBLE_LO    = 8'h0F;

    localparam logic [7:0]  RST_STROBE = 8'd1;
    localparam logic [9:0]  RST_EXEC   = 10'd40;
    localparam logic [15:0] RST_CLEAR  = 16'd2000;
    localparam logic [15:0] RST_HOME   = 16'd2000;

    typedef enum logic [1:0] {
        EXTRA_NONE  = 2'd0,
        EXTRA_CLEAR = 2'd1,
        EXTRA_HOME  = 2'd2
    } t_extra;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        t_extra     extra;
        logic       last;
    } t_byte_ent;

    typedef struct packed {
        logic [7:0]  strobe_us;
        logic [9:0]  exec_delay_us;
        logic [15:0] clear_delay_us;
        logic [15:0] home_delay_us;
    } t_cfg;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h30;
            3'd1:    b = 8'h28;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_HOME;
            3'd4:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

    function automatic t_extra cmd_extra(input logic [7:0] b);
        t_extra e;
        if (b == CMD_CLEAR) begin
            e = EXTRA_CLEAR;
        end else if (b == CMD_HOME) begin
            e = EXTRA_HOME;
        end else begin
            e = EXTRA_NONE;
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/lcdns_req_if.sv
// request channel: one lcd request per beat
interface lcdns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_code;
    logic       line;
    logic [5:0] column;

    modport source (output valid, output action, output char_code, output line,
                    output column, input ready);
    modport sink   (input valid, input action, input char_code, input line,
                    input column, output ready);
endinterface

// File: hw/rtl/lcdns_phase_if.sv
// phase channel: one lcd pin phase per beat
interface lcdns_phase_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  data_nibble;
    logic        enable;
    logic [16:0] hold_us;
    logic        last;

    modport source (output valid, output reg_select, output data_nibble,
                    output enable, output hold_us, output last, input ready);
    modport sink   (input valid, input reg_select, input data_nibble,
                    input enable, input hold_us, input last, output ready);
endinterface

// File: hw/rtl/char_lcd_nibble_sequencer.sv
// top level of the character lcd 4-bit nibble sequencer
// use: each beat on i_req is one request (initialize, clear, home, set cursor,
// write character); each beat on o_phase is one pin state for the display,
// held for hold_us microseconds by the downstream pin driver
// a byte is four phases, upper nibble first, enable high then low per nibble;
// the final phase of a request carries last
// a single-byte request is written to the byte queue when its beat is taken, and
// its first phase is then registered by the phase generator; an initialize request
// first sets the front end's init state, which then writes its bytes to the queue
// throughput: one phase per cycle while o_phase.ready holds and bytes are queued
// the byte queue (FIFO_DEPTH entries) lets new requests in while phases wait
// on a stalled receiver; a full queue or an initialize expansion drops ready
// a stalled receiver holds the current phase on o_phase unchanged
// reset clears the queue and the phase counter and loads the register
// defaults: strobe 1, exec 40, clear 2000, home 2000 microseconds
// configuration writes take effect at the next edge, meant while idle
module char_lcd_nibble_sequencer #(
    parameter int unsigned FIFO_DEPTH = lcdns_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lcdns_req_if.sink                          i_req,
    lcdns_phase_if.source                      o_phase,
    input  logic                               i_cfg_we,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcdns_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import lcdns_pkg::*;

    t_cfg       r_cfg;
    logic       full;
    logic       empty;
    logic       push;
    logic       pop;
    t_byte_ent  push_ent;
    t_byte_ent  head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_us      <= RST_STROBE;
            r_cfg.exec_delay_us  <= RST_EXEC;
            r_cfg.clear_delay_us <= RST_CLEAR;
            r_cfg.home_delay_us  <= RST_HOME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STROBE: r_cfg.strobe_us      <= i_cfg_wdata[7:0];
                CFG_EXEC:   r_cfg.exec_delay_us  <= i_cfg_wdata[9:0];
                CFG_CLEAR:  r_cfg.clear_delay_us <= i_cfg_wdata;
                CFG_HOME:   r_cfg.home_delay_us  <= i_cfg_wdata;
                default:    r_cfg.strobe_us      <= r_cfg.strobe_us;
            endcase
        end
    end

    lcdns_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_full     (full),
        .o_push     (push),
        .o_push_ent (push_ent)
    );

    lcdns_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_full     (full),
        .o_empty    (empty),
        .o_head     (head)
    );

    lcdns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_phase (o_phase)
    );

endmodule

// File: hw/rtl/lcdns_front.sv
// front end: accepts requests and expands them into classified bytes
module lcdns_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcdns_req_if.sink             i_req,
    input  logic                  i_full,
    output logic                  o_push,
    output lcdns_pkg::t_byte_ent  o_push_ent
);
    import lcdns_pkg::*;

    logic       r_init_active;
    logic [2:0] r_idx;
    logic       n_init_active;
    logic [2:0] n_idx;
    logic       accept;
    logic [7:0] init_b;

    assign i_req.ready = !r_init_active && !i_full;
    assign accept      = i_req.valid && i_req.ready;
    assign init_b      = init_byte(r_idx);

    always_comb begin
        n_init_active = r_init_active;
        n_idx         = r_idx;
        o_push        = 1'b0;
        o_push_ent    = '{rs: 1'b0, data: init_b, extra: cmd_extra(init_b),
                          last: (r_idx == 3'(INIT_LEN - 1))};
        if (r_init_active) begin
            if (!i_full) begin
                o_push = 1'b1;
                n_idx  = r_idx + 3'd1;
                if (r_idx == 3'(INIT_LEN - 1)) begin
                    n_init_active = 1'b0;
                end
            end
        end else if (accept) begin
            o_push_ent.last = 1'b1;
            unique case (i_req.action)
                ACT_INIT: begin
                    n_init_active = 1'b1;
                    n_idx         = 3'd0;
                end
                ACT_CLEAR: begin
                    o_push           = 1'b1;
                    o_push_ent.data  = CMD_CLEAR;
                    o_push_ent.extra = EXTRA_CLEAR;
                end
                ACT_HOME: begin
                    o_push           = 1'b1;
                    o_push_ent.data  = CMD_HOME;
                    o_push_ent.extra = EXTRA_HOME;
                end
                ACT_CURSOR: begin
                    o_push           = 1'b1;
                    o_push_ent.data  = CMD_DDRAM | {1'b0, i_req.line, i_req.column};
                    o_push_ent.extra = EXTRA_NONE;
                end
                ACT_CHAR: begin
                    o_push           = 1'b1;
                    o_push_ent.rs    = 1'b1;
                    o_push_ent.data  = i_req.char_code;
                    o_push_ent.extra = EXTRA_NONE;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_active <= 1'b0;
            r_idx         <= 3'd0;
        end else begin
            r_init_active <= n_init_active;
            r_idx         <= n_idx;
        end
    end

endmodule

// File: hw/rtl/lcdns_fifo.sv
// byte queue between the front end and the phase generator
module lcdns_fifo #(
    parameter int unsigned DEPTH = lcdns_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lcdns_pkg::t_byte_ent  i_push_ent,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output lcdns_pkg::t_byte_ent  o_head
);
    import lcdns_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_byte_ent          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/lcdns_back.sv
// back end: turns each queued byte into four registered pin phases
module lcdns_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcdns_pkg::t_cfg       i_cfg,
    input  logic                  i_empty,
    input  lcdns_pkg::t_byte_ent  i_head,
    output logic                  o_pop,
    lcdns_phase_if.source         o_phase
);
    import lcdns_pkg::*;

    logic                r_ov;
    logic [1:0]          r_phase;
    logic                r_rs;
    logic [3:0]          r_nib;
    logic                r_en;
    logic [HOLD_W-1:0]   r_hold;
    logic                r_last;
    logic                advance;
    logic [3:0]          nib;
    logic [HOLD_W-1:0]   extra;
    logic [HOLD_W-1:0]   tail;
    logic [HOLD_W-1:0]   strobe;

    assign advance = !r_ov || o_phase.ready;
    assign o_pop   = advance && !i_empty && (r_phase == 2'd3);

    assign strobe = HOLD_W'(i_cfg.strobe_us);
    assign nib    = r_phase[1] ? 4'(i_head.data & NIBBLE_LO)
                               : 4'((i_head.data & NIBBLE_HI) >> 4);

    always_comb begin
        unique case (i_head.extra)
            EXTRA_CLEAR: extra = HOLD_W'(i_cfg.clear_delay_us);
            EXTRA_HOME:  extra = HOLD_W'(i_cfg.home_delay_us);
            default:     extra = '0;
        endcase
    end

    assign tail = strobe + HOLD_W'(i_cfg.exec_delay_us) + extra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_phase <= 2'd0;
        end else if (advance) begin
            r_ov <= !i_empty;
            if (!i_empty) begin
                r_phase <= r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_empty) begin
            r_rs   <= i_head.rs;
            r_nib  <= nib;
            r_en   <= !r_phase[0];
            r_hold <= (r_phase == 2'd3) ? tail : strobe;
            r_last <= i_head.last && (r_phase == 2'd3);
        end
    end

    assign o_phase.valid       = r_ov;
    assign o_phase.reg_select  = r_rs;
    assign o_phase.data_nibble = r_nib;
    assign o_phase.enable      = r_en;
    assign o_phase.hold_us     = r_hold;
    assign o_phase.last        = r_last;

endmodule
